>>> src/drs_pkg.sv
package drs_pkg;

  // Bits held in one word of the store; walks move one word a cycle.
  localparam int WordBits = 64;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_RANK   = 3'd4,
    OP_SELECT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic find;
    logic load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_err;
    logic walk_done;
    logic is_select;
    logic find_done;
  } dp_sts_t;

  function automatic logic [6:0] popcount64(input logic [63:0] w);
    logic [6:0] c;
    c = '0;
    for (int i = 0; i < 64; i++) begin
      c = c + 7'(w[i]);
    end
    return c;
  endfunction

  function automatic logic [3:0] popcount8(input logic [7:0] w);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(w[i]);
    end
    return c;
  endfunction

endpackage

>>> src/drs_ctrl.sv
module drs_ctrl
  import drs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_FIND = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.start_err ? S_LOAD : S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = sts_i.is_select ? S_FIND : S_LOAD;
        end
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        if (sts_i.find_done) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // The result register is free, or frees up at this very edge.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/drs_datapath.sv
module drs_datapath
  import drs_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [2:0]  op_i,
  input  logic [10:0] index_i,
  input  logic        bit_value_i,
  output logic        read_bit_o,
  output logic [10:0] rank_count_o,
  output logic [9:0]  found_position_o,
  output logic [1:0]  status_o,
  output logic [10:0] length_now_o,
  output logic [10:0] ones_now_o
);

  localparam int Words = CAPACITY / WordBits;
  localparam int WA    = (Words > 1) ? $clog2(Words) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int CW    = (CntW > 11) ? CntW : 11;

  logic [63:0]    mem [Words];
  logic [63:0]    mem_rdata_q;

  logic [CW-1:0]  len_q, ones_q, acc_q, idx_q, eidx_q, pos_q;
  logic [2:0]     op_q;
  logic           val_q;
  status_e        status_q;
  logic [WA-1:0]  rd_addr_q, last_addr_q, proc_addr_q, fword_q;
  logic           rd_busy_q, pend_q, proc_last_q, down_q, carry_q, rd_bit_q, found_q;
  logic [63:0]    fdata_q;
  logic [6:0]     resid_q;
  logic [2:0]     byte_q;

  // Request decode and range checks
  logic [CW-1:0]  idx_x, s_pos, e_pos;
  status_e        st;
  logic           dn;

  always_comb begin
    idx_x = CW'(index_i);
    st    = ST_OK;
    s_pos = idx_x;
    e_pos = idx_x;
    dn    = 1'b0;
    unique case (op_i) inside
      OP_READ, OP_SET: begin
        if (idx_x >= len_q) st = ST_RANGE;
      end
      OP_INSERT: begin
        if (idx_x > len_q) st = ST_RANGE;
        else if (len_q == CW'(CAPACITY)) st = ST_FULL;
        e_pos = len_q;
      end
      OP_DELETE: begin
        if (idx_x >= len_q) st = ST_RANGE;
        s_pos = len_q - CW'(1);
        dn    = 1'b1;
      end
      OP_RANK: begin
        s_pos = '0;
        if (len_q == '0) e_pos = '0;
        else if (idx_x >= len_q) e_pos = len_q - CW'(1);
      end
      OP_SELECT: begin
        if (idx_x == '0 || idx_x > ones_q) st = ST_RANGE;
        s_pos = '0;
        e_pos = len_q - CW'(1);
      end
      default: st = ST_RANGE;
    endcase
  end

  // Word processing
  logic [CW-1:0] word_x, lenw, sum;
  logic [63:0]   vmask, d, low, bitb, sh, wdata, rmask;
  logic [5:0]    b;
  logic          at_idx, we;
  logic [6:0]    pop;

  always_comb begin
    word_x = CW'(proc_addr_q);
    lenw   = len_q >> 6;
    if (word_x < lenw) vmask = '1;
    else if (word_x == lenw) vmask = (64'(1) << len_q[5:0]) - 64'(1);
    else vmask = '0;
    d      = mem_rdata_q & vmask;
    b      = idx_q[5:0];
    bitb   = 64'(1) << b;
    low    = bitb - 64'(1);
    at_idx = (word_x == (idx_q >> 6));
    sh     = {carry_q, d[63:1]};
    case (op_q)
      OP_SET:    wdata = (d & ~bitb) | (val_q ? bitb : '0);
      OP_INSERT: wdata = at_idx ? ((d & low) | (val_q ? bitb : '0) | ((d << 1) & ~(low | bitb)))
                                : {d[62:0], carry_q};
      OP_DELETE: wdata = at_idx ? ((d & low) | (sh & ~low)) : sh;
      default:   wdata = d;
    endcase
    we    = pend_q && (op_q == OP_SET || op_q == OP_INSERT || op_q == OP_DELETE);
    rmask = (proc_last_q && op_q == OP_RANK) ? ~((~64'(0) << eidx_q[5:0]) << 1) : '1;
    pop   = popcount64(d & rmask);
    sum   = acc_q + CW'(pop);
  end

  // Search for the wanted one inside one byte of the found word
  logic [7:0] fbyte;
  logic [3:0] pb, cnt;
  logic [2:0] jpos;
  logic       hit, find_done;

  always_comb begin
    fbyte = fdata_q[byte_q*8 +: 8];
    pb    = popcount8(fbyte);
    cnt   = '0;
    jpos  = '0;
    hit   = 1'b0;
    for (int j = 0; j < 8; j++) begin
      cnt = cnt + 4'(fbyte[j]);
      if (!hit && fbyte[j] && (7'(cnt) == resid_q)) begin
        hit  = 1'b1;
        jpos = 3'(j);
      end
    end
    find_done = cmd_i.find && (resid_q <= 7'(pb));
  end

  assign sts_o.start_err = (st != ST_OK);
  assign sts_o.walk_done = pend_q && proc_last_q;
  assign sts_o.is_select = (op_q == OP_SELECT);
  assign sts_o.find_done = find_done;

  always_ff @(posedge clk_i) begin
    if (rd_busy_q) begin
      mem_rdata_q <= mem[rd_addr_q];
    end
    if (we) begin
      mem[proc_addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ones_q      <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      eidx_q      <= '0;
      pos_q       <= '0;
      op_q        <= '0;
      val_q       <= 1'b0;
      status_q    <= ST_OK;
      rd_addr_q   <= '0;
      last_addr_q <= '0;
      proc_addr_q <= '0;
      fword_q     <= '0;
      rd_busy_q   <= 1'b0;
      pend_q      <= 1'b0;
      proc_last_q <= 1'b0;
      down_q      <= 1'b0;
      carry_q     <= 1'b0;
      rd_bit_q    <= 1'b0;
      found_q     <= 1'b0;
      fdata_q     <= '0;
      resid_q     <= '0;
      byte_q      <= '0;
    end else begin
      if (cmd_i.start) begin
        op_q     <= op_i;
        idx_q    <= idx_x;
        val_q    <= bit_value_i;
        eidx_q   <= e_pos;
        status_q <= st;
        acc_q    <= '0;
        pos_q    <= '0;
        found_q  <= 1'b0;
        carry_q  <= 1'b0;
        rd_bit_q <= 1'b0;
        if (st == ST_OK) begin
          rd_busy_q   <= 1'b1;
          rd_addr_q   <= s_pos[WA+5:6];
          last_addr_q <= e_pos[WA+5:6];
          down_q      <= dn;
        end
      end

      if (rd_busy_q) begin
        pend_q      <= 1'b1;
        proc_addr_q <= rd_addr_q;
        proc_last_q <= (rd_addr_q == last_addr_q);
        if (rd_addr_q == last_addr_q) rd_busy_q <= 1'b0;
        else if (down_q) rd_addr_q <= rd_addr_q - WA'(1);
        else rd_addr_q <= rd_addr_q + WA'(1);
      end else begin
        pend_q <= 1'b0;
      end

      if (pend_q) begin
        case (op_q)
          OP_READ: rd_bit_q <= d[b];
          OP_SET: begin
            if (d[b] != val_q) ones_q <= val_q ? ones_q + CW'(1) : ones_q - CW'(1);
          end
          OP_INSERT: begin
            carry_q <= d[63];
            if (proc_last_q) begin
              len_q  <= len_q + CW'(1);
              ones_q <= ones_q + CW'(val_q);
            end
          end
          OP_DELETE: begin
            carry_q <= d[0];
            if (proc_last_q) begin
              len_q  <= len_q - CW'(1);
              ones_q <= ones_q - CW'(d[b]);
            end
          end
          OP_RANK: acc_q <= sum;
          OP_SELECT: begin
            if (!found_q) begin
              if (sum >= idx_q) begin
                found_q <= 1'b1;
                fdata_q <= d;
                fword_q <= proc_addr_q;
                resid_q <= 7'(idx_q - acc_q);
                byte_q  <= '0;
              end else begin
                acc_q <= sum;
              end
            end
          end
          default: ;
        endcase
      end

      if (cmd_i.find) begin
        if (find_done) begin
          pos_q <= (CW'(fword_q) << 6) | CW'({byte_q, jpos});
        end else begin
          resid_q <= resid_q - 7'(pb);
          byte_q  <= byte_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      read_bit_o       <= rd_bit_q;
      rank_count_o     <= (op_q == OP_RANK) ? acc_q[10:0] : 11'd0;
      found_position_o <= pos_q[9:0];
      status_o         <= status_q;
      length_now_o     <= len_q[10:0];
      ones_now_o       <= ones_q[10:0];
    end
  end

`ifndef ASSERT_OFF
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CW'(CAPACITY)) else $error("stored length above capacity");
  a_ones_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ones_q <= len_q) else $error("ones count above stored length");
  a_find_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.find |-> found_q) else $error("byte search without a found word");
  a_walk_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !rd_busy_q && !pend_q) else $error("request taken during a walk");
`endif

endmodule

>>> src/dynamic_rank_select_bit_store.sv
// Dynamic rank/select bit store. The block keeps a sequence of up to CAPACITY
// bits (a multiple of 64) in a single-port-write, single-port-read memory of
// 64-bit words, together with its length and its count of ones, and serves one
// request at a time: read, set, insert, delete, rank and select. Each request
// is taken as a transfer on the input channel and yields exactly one result
// transfer. A request that fails its range check skips the walk and goes
// straight to loading its result. Every other request walks the memory one
// word per cycle through the registered read port: read and set visit one
// word; insert visits the words from the insert position up to the end of
// the sequence, delete the words from the end down to the delete position,
// rank the words up to the clamped position, and select every word of the
// sequence followed by a scan of the found word one byte at a time. At the
// default capacity of 1024 bits a full walk covers 16 words. No clearing
// pass follows reset: bits at or beyond the current length are masked on
// every read. A finished result sits in an output register, so the next
// request is taken while it waits for its transfer.
module dynamic_rank_select_bit_store
  import drs_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [10:0] index_i,
  input  logic        bit_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        read_bit_o,
  output logic [10:0] rank_count_o,
  output logic [9:0]  found_position_o,
  output logic [1:0]  status_o,
  output logic [10:0] length_now_o,
  output logic [10:0] ones_now_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences each request and owns the output valid flag.
  drs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the word memory, the counters and the result register.
  drs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .index_i          (index_i),
    .bit_value_i      (bit_value_i),
    .read_bit_o       (read_bit_o),
    .rank_count_o     (rank_count_o),
    .found_position_o (found_position_o),
    .status_o         (status_o),
    .length_now_o     (length_now_o),
    .ones_now_o       (ones_now_o)
  );

endmodule
